// ===== sv/tdbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdbf_pkg
// Shared constants for the temporal depth blend filter.
// ----------------------------------------------------------------------------
package tdbf_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int PIX_W      = 17;
	localparam int SUM_W      = 33;
	localparam int CFG_W      = 17;
	localparam int CFG_IDX_W  = 2;

	localparam logic [16:0] ONE_Q16      = 17'd65536;
	localparam logic [15:0] ALPHA_MAX    = 16'd62259;
	localparam logic [15:0] BYPASS_LIMIT = 16'd65;
	localparam logic [16:0] EDGE_LIMIT   = 17'd26214;
	localparam logic [18:0] DIV3_MUL     = 19'd349526;

	localparam logic [2:0] PIX_LAT = 3'd7;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_EMIT  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] REG_STABILITY    = 2'd0;
	localparam logic [1:0] REG_FLICKER_GAIN = 2'd1;
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

// ===== sv/tdbf_req_if.sv =====
// ----------------------------------------------------------------------------
// tdbf_req_if
// Request channel: operation code and depth sample.
// ----------------------------------------------------------------------------
interface tdbf_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          op;
	tdbf_pkg::pix_t      depth_in;

	modport source (output valid, output op, output depth_in, input ready);
	modport sink (input valid, input op, input depth_in, output ready);
endinterface

// ===== sv/tdbf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tdbf_rsp_if
// Result channel: stabilized depth sample and flags.
// ----------------------------------------------------------------------------
interface tdbf_rsp_if;
	logic           valid;
	logic           ready;
	tdbf_pkg::pix_t depth_out;
	logic           end_of_frame;
	logic           status;

	modport source (output valid, output depth_out, output end_of_frame, output status,
		input ready);
	modport sink (input valid, input depth_out, input end_of_frame, input status,
		output ready);
endinterface

// ===== sv/tdbf_ram.sv =====
// ----------------------------------------------------------------------------
// tdbf_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module tdbf_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/tdbf_div.sv =====
// ----------------------------------------------------------------------------
// tdbf_div
// Restoring divider for the frame mean, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdbf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tdbf_pkg::SUM_W-1:0]    dividend,
	input  logic [tdbf_pkg::CNT_W-1:0]    divisor,
	output logic                          busy,
	output logic [tdbf_pkg::PIX_W-1:0]    quotient
);

	logic [tdbf_pkg::SUM_W-1:0] quo_q;
	logic [tdbf_pkg::CNT_W-1:0] rem_q;
	logic [tdbf_pkg::CNT_W-1:0] dvs_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q;
	logic [tdbf_pkg::CNT_W:0]   shifted;
	logic [tdbf_pkg::CNT_W:0]   diff;
	logic                       fits;

	assign shifted = {rem_q, quo_q[tdbf_pkg::SUM_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(tdbf_pkg::SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[tdbf_pkg::CNT_W-1:0] : shifted[tdbf_pkg::CNT_W-1:0];
			quo_q <= {quo_q[tdbf_pkg::SUM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q[tdbf_pkg::PIX_W-1:0];

endmodule

// ===== sv/tdbf_pix.sv =====
// ----------------------------------------------------------------------------
// tdbf_pix
// Pixel datapath: flicker removal, clamp, adaptive alpha and history blend.
// ----------------------------------------------------------------------------
module tdbf_pix (
	input  logic                  clk,
	input  tdbf_pkg::pix_t        pix,
	input  tdbf_pkg::pix_t        prev,
	input  logic signed [17:0]    offset,
	input  logic [15:0]           stability,
	output tdbf_pkg::pix_t        result
);

	logic signed [18:0] cs;
	logic [16:0]        d;

	tdbf_pkg::pix_t c_s1, c_s2, c_s3, c_s4, c_s5;
	tdbf_pkg::pix_t p_s1, p_s2, p_s3, p_s4, p_s5;
	logic [15:0]    ab_s1, ab_s2, ab_s3, ab_s4;
	logic           edge_s2, edge_s3, edge_s4;
	logic [16:0]    rest_s2;
	logic [32:0]    prod_s3;
	logic [19:0]    y_s4;
	logic [16:0]    alpha_s5;
	logic [33:0]    m1_s6, m2_s6;
	logic [35:0]    t4;
	logic [38:0]    t5;
	logic [34:0]    t7;

	assign cs = $signed({2'b00, pix}) - {offset[17], offset};
	assign d  = (c_s1 > p_s1) ? (c_s1 - p_s1) : (p_s1 - c_s1);
	assign t4 = {3'b000, prod_s3} * 36'd5 + 36'd98304;
	assign t5 = {19'd0, y_s4} * {20'd0, tdbf_pkg::DIV3_MUL};
	assign t7 = {1'b0, m1_s6} + {1'b0, m2_s6} + 35'd32768;

	always_ff @(posedge clk) begin
		// Stage 1: remove the flicker offset and clamp to 0..1.
		if (cs < 0) begin
			c_s1 <= '0;
		end else if (cs > $signed({2'b00, tdbf_pkg::ONE_Q16})) begin
			c_s1 <= tdbf_pkg::ONE_Q16;
		end else begin
			c_s1 <= cs[16:0];
		end
		p_s1  <= prev;
		ab_s1 <= (stability > tdbf_pkg::ALPHA_MAX) ? tdbf_pkg::ALPHA_MAX : stability;

		// Stage 2: difference to history.
		edge_s2 <= d > tdbf_pkg::EDGE_LIMIT;
		rest_s2 <= (d >= tdbf_pkg::ONE_Q16) ? 17'd0 : (tdbf_pkg::ONE_Q16 - d);
		c_s2    <= c_s1;
		p_s2    <= p_s1;
		ab_s2   <= ab_s1;

		// Stage 3: alpha times remaining headroom.
		prod_s3 <= {17'd0, ab_s2} * {16'd0, rest_s2};
		edge_s3 <= edge_s2;
		c_s3    <= c_s2;
		p_s3    <= p_s2;
		ab_s3   <= ab_s2;

		// Stage 4 and 5: divide by 0.6 with rounding, the last step by 3.
		y_s4    <= t4[35:16];
		edge_s4 <= edge_s3;
		c_s4    <= c_s3;
		p_s4    <= p_s3;
		ab_s4   <= ab_s3;

		alpha_s5 <= edge_s4 ? {1'b0, t5[35:20]} : {1'b0, ab_s4};
		c_s5     <= c_s4;
		p_s5     <= p_s4;

		// Stage 6 and 7: blend and round.
		m1_s6 <= (tdbf_pkg::ONE_Q16 - alpha_s5) * {17'd0, c_s5};
		m2_s6 <= {17'd0, alpha_s5} * {17'd0, p_s5};

		if (t7[34:16] > {2'b00, tdbf_pkg::ONE_Q16}) begin
			result <= tdbf_pkg::ONE_Q16;
		end else begin
			result <= t7[32:16];
		end
	end

endmodule

// ===== sv/temporal_depth_blend_filter.sv =====
// ----------------------------------------------------------------------------
// temporal_depth_blend_filter
// Flow: a load leaves the block idle; the last load of a frame holds the input
// through the mean division, one handover state and two of flicker setup.
// An emit holds it through the RAM read and the 7-stage pixel datapath.
// One item is in flight at a time. Reset clears all control state; the
// frame and history buffers are not cleared.
// ----------------------------------------------------------------------------
module temporal_depth_blend_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tdbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdbf_pkg::CFG_W-1:0]        cfg_data,
	tdbf_req_if.sink                          req,
	tdbf_rsp_if.source                        rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_FX1  = 3'd2;
	localparam logic [2:0] ST_FX2  = 3'd3;
	localparam logic [2:0] ST_PIX  = 3'd4;
	localparam logic [2:0] ST_ERR  = 3'd5;

	localparam int AW = tdbf_pkg::ADDR_W;
	localparam int CW = tdbf_pkg::CNT_W;

	logic [15:0]              stab_q;
	logic [16:0]              gain_q;
	logic [8:0]               fw_q, fh_q;
	logic [tdbf_pkg::SUM_W-1:0] sum_q;
	logic [16:0]              prev_mean_q;
	logic signed [17:0]       offset_q;
	logic                     hist_valid_q;
	logic [CW-1:0]            load_pos_q, emit_pos_q, count_q;
	logic                     loaded_q, bypass_q;
	logic [8:0]               last_w_q, last_h_q;
	logic [2:0]               state_q, wait_q;
	logic                     neg_q;
	logic [16:0]              mag_q;
	logic                     out_valid_q, out_eof_q, out_status_q;
	tdbf_pkg::pix_t           out_data_q;

	logic [8:0]               w_eff, h_eff;
	logic [17:0]              area;
	logic [CW-1:0]            n_pix, lp_next, ep_next;
	logic                     accept, is_load, is_emit, frame_done, out_free, hist_we;
	logic                     out_load;
	tdbf_pkg::pix_t           dep_sat, cur_rd, hist_rd, pix_res, res_val;
	logic [tdbf_pkg::SUM_W-1:0] sum_next, dividend;
	logic                     div_busy;
	tdbf_pkg::pix_t           mean;
	logic [16:0]              gain_c;
	logic [33:0]              corr_full;

	assign w_eff   = (fw_q == 9'd0) ? 9'd1 : fw_q;
	assign h_eff   = (fh_q == 9'd0) ? 9'd1 : fh_q;
	assign area    = w_eff * h_eff;
	assign n_pix   = (area > 18'(tdbf_pkg::MAX_PIXELS)) ? CW'(tdbf_pkg::MAX_PIXELS)
		: area[CW-1:0];

	assign req.ready  = state_q == ST_IDLE;
	assign accept     = req.valid && req.ready;
	assign dep_sat    = (req.depth_in > tdbf_pkg::ONE_Q16) ? tdbf_pkg::ONE_Q16 : req.depth_in;
	assign is_load    = accept && req.op == tdbf_pkg::OP_LOAD && !loaded_q;
	assign is_emit    = accept && req.op == tdbf_pkg::OP_EMIT;
	assign lp_next    = load_pos_q + CW'(1);
	assign ep_next    = emit_pos_q + CW'(1);
	assign frame_done = is_load && lp_next >= n_pix;
	assign sum_next   = sum_q + {16'd0, dep_sat};
	assign dividend   = sum_next + {16'd0, n_pix >> 1};
	assign out_free   = !out_valid_q || rsp.ready;
	assign res_val    = bypass_q ? cur_rd : pix_res;
	assign hist_we    = state_q == ST_PIX && wait_q == 3'd0 && out_free;
	assign out_load   = hist_we || (state_q == ST_ERR && out_free);
	assign gain_c     = (gain_q > tdbf_pkg::ONE_Q16) ? tdbf_pkg::ONE_Q16 : gain_q;
	assign corr_full  = {17'd0, mag_q} * {17'd0, gain_c} + 34'd32768;

	tdbf_ram #(.WIDTH(tdbf_pkg::PIX_W), .DEPTH(tdbf_pkg::MAX_PIXELS)) u_cur_ram (
		.clk   (clk),
		.we    (is_load),
		.waddr (load_pos_q[AW-1:0]),
		.wdata (dep_sat),
		.re    (is_emit && loaded_q),
		.raddr (emit_pos_q[AW-1:0]),
		.rdata (cur_rd)
	);

	tdbf_ram #(.WIDTH(tdbf_pkg::PIX_W), .DEPTH(tdbf_pkg::MAX_PIXELS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (emit_pos_q[AW-1:0]),
		.wdata (res_val),
		.re    (is_emit && loaded_q),
		.raddr (emit_pos_q[AW-1:0]),
		.rdata (hist_rd)
	);

	tdbf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (frame_done),
		.dividend (dividend),
		.divisor  (n_pix),
		.busy     (div_busy),
		.quotient (mean)
	);

	tdbf_pix u_pix (
		.clk       (clk),
		.pix       (cur_rd),
		.prev      (hist_rd),
		.offset    (offset_q),
		.stability (stab_q),
		.result    (pix_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stab_q <= '0;
			gain_q <= '0;
			fw_q   <= 9'd256;
			fh_q   <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdbf_pkg::REG_STABILITY:    stab_q <= cfg_data[15:0];
				tdbf_pkg::REG_FLICKER_GAIN: gain_q <= cfg_data;
				tdbf_pkg::REG_FRAME_WIDTH:  fw_q   <= cfg_data[8:0];
				tdbf_pkg::REG_FRAME_HEIGHT: fh_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wait_q       <= '0;
			sum_q        <= '0;
			prev_mean_q  <= '0;
			offset_q     <= '0;
			hist_valid_q <= 1'b0;
			load_pos_q   <= '0;
			emit_pos_q   <= '0;
			count_q      <= '0;
			loaded_q     <= 1'b0;
			bypass_q     <= 1'b0;
			last_w_q     <= '0;
			last_h_q     <= '0;
			neg_q        <= 1'b0;
			mag_q        <= '0;
			out_valid_q  <= 1'b0;
			out_eof_q    <= 1'b0;
			out_status_q <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.op == tdbf_pkg::OP_CLEAR) begin
						hist_valid_q <= 1'b0;
					end
					if (is_load) begin
						if (frame_done) begin
							bypass_q <= stab_q <= tdbf_pkg::BYPASS_LIMIT || !hist_valid_q
								|| w_eff != last_w_q || h_eff != last_h_q;
							last_w_q     <= w_eff;
							last_h_q     <= h_eff;
							hist_valid_q <= 1'b1;
							count_q      <= n_pix;
							loaded_q     <= 1'b1;
							emit_pos_q   <= '0;
							load_pos_q   <= '0;
							sum_q        <= '0;
							state_q      <= ST_DIV;
						end else begin
							load_pos_q <= lp_next;
							sum_q      <= sum_next;
						end
					end
					if (is_emit) begin
						if (loaded_q) begin
							wait_q  <= tdbf_pkg::PIX_LAT;
							state_q <= ST_PIX;
						end else begin
							state_q <= ST_ERR;
						end
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_FX1;
					end
				end
				ST_FX1: begin
					neg_q       <= mean < prev_mean_q;
					mag_q       <= (mean < prev_mean_q) ? (prev_mean_q - mean)
						: (mean - prev_mean_q);
					prev_mean_q <= mean;
					state_q     <= ST_FX2;
				end
				ST_FX2: begin
					offset_q <= neg_q ? -$signed({1'b0, corr_full[32:16]})
						: $signed({1'b0, corr_full[32:16]});
					state_q  <= ST_IDLE;
				end
				ST_PIX: begin
					if (wait_q != 3'd0) begin
						wait_q <= wait_q - 3'd1;
					end else if (out_free) begin
						out_data_q   <= res_val;
						out_status_q <= 1'b0;
						out_eof_q    <= ep_next >= count_q;
						if (ep_next >= count_q) begin
							loaded_q   <= 1'b0;
							emit_pos_q <= '0;
						end else begin
							emit_pos_q <= ep_next;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						out_data_q   <= '0;
						out_eof_q    <= 1'b0;
						out_status_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.depth_out    = out_data_q;
	assign rsp.end_of_frame = out_eof_q;
	assign rsp.status       = out_status_q;

endmodule

// ===== sim/temporal_depth_blend_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_depth_blend_filter_tb
// Sends load, emit, clear and idle requests to the depth filter. Every
// stabilized pixel it returns is checked against a cycle-free model of the
// mean, flicker and blend arithmetic, under several register settings and
// random stalls on both channels.
// ----------------------------------------------------------------------------
module temporal_depth_blend_filter_tb;

	typedef struct packed {
		logic [1:0]     op;
		tdbf_pkg::pix_t depth;
	} depth_req_t;

	typedef struct packed {
		tdbf_pkg::pix_t depth;
		logic           eof;
		logic           status;
	} depth_rsp_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [tdbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tdbf_pkg::CFG_W-1:0] cfg_data = '0;

	tdbf_req_if req_ch ();
	tdbf_rsp_if rsp_ch ();

	temporal_depth_blend_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	depth_req_t pending_reqs[$];
	depth_rsp_t expected_pixels[$];
	int         err_cnt = 0;
	bit         gaps_on = 1'b1;
	bit         req_busy = 1'b0;
	bit         hold_go = 1'b0;
	bit         hold_done = 1'b0;
	int         items_sent = 0;

	// Filter state as seen from outside.
	tdbf_pkg::pix_t cur_buf[tdbf_pkg::MAX_PIXELS];
	tdbf_pkg::pix_t hist_buf[tdbf_pkg::MAX_PIXELS];
	longint  sum_acc;
	longint  prev_mean;
	longint  flk_ofs;
	bit      hist_ok, frame_ready, bypass_on;
	int      load_pos, emit_pos, last_w, last_h, loaded_n;
	longint  stab_reg, gain_reg;
	int      width_reg, height_reg;

	function automatic int frame_pixels();
		longint w, h, n;
		w = (width_reg == 0) ? 1 : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		n = w * h;
		return (n > tdbf_pkg::MAX_PIXELS) ? tdbf_pkg::MAX_PIXELS : int'(n);
	endfunction

	function automatic longint blend_pixel(longint pix, longint prev);
		longint c, d, alpha, rest, s;
		c = pix - flk_ofs;
		if (c < 0)
			c = 0;
		if (c > tdbf_pkg::ONE_Q16)
			c = tdbf_pkg::ONE_Q16;
		d = (c > prev) ? c - prev : prev - c;
		alpha = (stab_reg > tdbf_pkg::ALPHA_MAX) ? tdbf_pkg::ALPHA_MAX : stab_reg;
		if (d > tdbf_pkg::EDGE_LIMIT) begin
			rest = (d >= tdbf_pkg::ONE_Q16) ? 0 : tdbf_pkg::ONE_Q16 - d;
			alpha = (alpha * rest * 5 + 98304) / 196608;
		end
		s = ((tdbf_pkg::ONE_Q16 - alpha) * c + alpha * prev + 32768) >>> 16;
		return (s > tdbf_pkg::ONE_Q16) ? tdbf_pkg::ONE_Q16 : s;
	endfunction

	// Updates the model for one accepted item and queues any pixel it yields.
	function automatic void predict_pixel(depth_req_t it);
		depth_rsp_t r;
		longint     dep, mean, g, mag, corr, res;
		int         n, w, h;
		case (it.op)
			tdbf_pkg::OP_LOAD: begin
				if (!frame_ready) begin
					dep = (it.depth > tdbf_pkg::ONE_Q16) ? tdbf_pkg::ONE_Q16 : it.depth;
					n = frame_pixels();
					if (load_pos < tdbf_pkg::MAX_PIXELS)
						cur_buf[load_pos] = tdbf_pkg::pix_t'(dep);
					sum_acc += dep;
					load_pos++;
					if (load_pos >= n) begin
						w = (width_reg == 0) ? 1 : width_reg;
						h = (height_reg == 0) ? 1 : height_reg;
						mean = (sum_acc + n / 2) / n;
						g = (gain_reg > tdbf_pkg::ONE_Q16) ? tdbf_pkg::ONE_Q16 : gain_reg;
						mag = (mean < prev_mean) ? prev_mean - mean : mean - prev_mean;
						corr = (mag * g + 32768) >>> 16;
						bypass_on = (stab_reg <= tdbf_pkg::BYPASS_LIMIT) || !hist_ok
							|| w != last_w || h != last_h;
						flk_ofs = (mean < prev_mean) ? -corr : corr;
						prev_mean = mean;
						last_w = w;
						last_h = h;
						hist_ok = 1'b1;
						loaded_n = n;
						frame_ready = 1'b1;
						emit_pos = 0;
						load_pos = 0;
						sum_acc = 0;
					end
				end
			end
			tdbf_pkg::OP_CLEAR: hist_ok = 1'b0;
			tdbf_pkg::OP_EMIT: begin
				if (!frame_ready) begin
					r.depth = '0;
					r.eof = 1'b0;
					r.status = 1'b1;
				end else begin
					res = bypass_on ? cur_buf[emit_pos]
						: blend_pixel(cur_buf[emit_pos], hist_buf[emit_pos]);
					hist_buf[emit_pos] = tdbf_pkg::pix_t'(res);
					emit_pos++;
					r.depth = tdbf_pkg::pix_t'(res);
					r.eof = (emit_pos >= loaded_n);
					r.status = 1'b0;
					if (r.eof) begin
						frame_ready = 1'b0;
						emit_pos = 0;
					end
				end
				expected_pixels.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// Request driver.
	depth_req_t drv_item;
	int         drv_gap;
	always @(posedge clk or negedge arst_n) begin
		bit nv;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= tdbf_pkg::OP_NOP;
			req_ch.depth_in <= '0;
			drv_gap = 0;
			req_busy = 1'b0;
		end else begin
			nv = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				predict_pixel(drv_item);
				nv = 1'b0;
			end
			if (!nv) begin
				if (drv_gap > 0)
					drv_gap--;
				else if (pending_reqs.size() > 0) begin
					// The cycle that starts a gap is idle too.
					if (gaps_on && $urandom_range(0, 9) == 0)
						drv_gap = $urandom_range(1, 7) - 1;
					else begin
						drv_item = pending_reqs.pop_front();
						req_ch.op <= drv_item.op;
						req_ch.depth_in <= drv_item.depth;
						nv = 1'b1;
					end
				end
			end
			req_ch.valid <= nv;
			req_busy = nv;
		end
	end

	// Result monitor with its own stalls and one long hold-off.
	int stall_left;
	int hold_cnt;
	always @(posedge clk or negedge arst_n) begin
		depth_rsp_t e;
		bit nr;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			hold_cnt = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_pixels.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected item depth %0d eof %0d status %0d", $time,
						rsp_ch.depth_out, rsp_ch.end_of_frame, rsp_ch.status);
				end else begin
					e = expected_pixels.pop_front();
					if (rsp_ch.depth_out !== e.depth) begin
						err_cnt++;
						$display("%0t: depth_out expected %0d actual %0d", $time,
							e.depth, rsp_ch.depth_out);
					end
					if (rsp_ch.end_of_frame !== e.eof) begin
						err_cnt++;
						$display("%0t: end_of_frame expected %0d actual %0d", $time,
							e.eof, rsp_ch.end_of_frame);
					end
					if (rsp_ch.status !== e.status) begin
						err_cnt++;
						$display("%0t: status expected %0d actual %0d", $time,
							e.status, rsp_ch.status);
					end
				end
			end
			if (hold_go && !hold_done) begin
				hold_cnt++;
				nr = 1'b0;
				if (hold_cnt >= 400)
					hold_done = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				nr = 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			rsp_ch.ready <= nr;
		end
	end

	// Watchdog on handshake activity.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we
			|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_req(input logic [1:0] op, input int unsigned d);
		depth_req_t it;
		it.op = op;
		it.depth = tdbf_pkg::pix_t'(d);
		pending_reqs.push_back(it);
		items_sent++;
	endtask

	// Waits until the block has drained, then lets the longest latency pass.
	task automatic drain_block();
		while (pending_reqs.size() != 0 || req_busy || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= tdbf_pkg::CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			tdbf_pkg::REG_STABILITY:    stab_reg = val & 16'hFFFF;
			tdbf_pkg::REG_FLICKER_GAIN: gain_reg = val & 17'h1FFFF;
			tdbf_pkg::REG_FRAME_WIDTH:  width_reg = val & 9'h1FF;
			default:                    height_reg = val & 9'h1FF;
		endcase
	endtask

	task automatic set_filter(input int unsigned s, input int unsigned g,
		input int unsigned w, input int unsigned h);
		drain_block();
		write_reg(tdbf_pkg::REG_STABILITY, s);
		write_reg(tdbf_pkg::REG_FLICKER_GAIN, g);
		write_reg(tdbf_pkg::REG_FRAME_WIDTH, w);
		write_reg(tdbf_pkg::REG_FRAME_HEIGHT, h);
	endtask

	function automatic int unsigned pick_depth(int base);
		int v;
		case ($urandom_range(0, 15))
			0: return 0;
			1: return tdbf_pkg::ONE_Q16;
			2: return $urandom & 17'h1FFFF;
			3: return $urandom_range(0, 65536);
			default: begin
				v = base + $urandom_range(0, 8000) - 4000;
				if (v < 0)
					v = 0;
				if (v > tdbf_pkg::ONE_Q16)
					v = tdbf_pkg::ONE_Q16;
				return v;
			end
		endcase
	endfunction

	// One well-formed frame with some noise: stray clears, no-ops, ignored
	// loads and emits beyond the frame end.
	task automatic send_frame(inout int base);
		int n;
		n = frame_pixels();
		base = base + $urandom_range(0, 20000) - 10000;
		if (base < 0)
			base = 0;
		if (base > tdbf_pkg::ONE_Q16)
			base = tdbf_pkg::ONE_Q16;
		if ($urandom_range(0, 9) == 0)
			push_req(tdbf_pkg::OP_CLEAR, $urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 29) == 0)
				push_req(tdbf_pkg::OP_NOP, $urandom);
			push_req(tdbf_pkg::OP_LOAD, pick_depth(base));
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 29) == 0)
				push_req(tdbf_pkg::OP_LOAD, $urandom);
			if ($urandom_range(0, 39) == 0)
				push_req(tdbf_pkg::OP_CLEAR, $urandom);
			push_req(tdbf_pkg::OP_EMIT, $urandom);
		end
		if ($urandom_range(0, 9) == 0)
			push_req(tdbf_pkg::OP_EMIT, $urandom);
	endtask

	initial begin
		int base;
		int frames;
		int unsigned s, g, w, h;
		int unsigned stab_pick[9];
		int unsigned gain_pick[5];

		stab_pick = '{0, 65, 66, 1000, 30000, 52000, 62259, 62260, 65535};
		gain_pick = '{0, 32768, 65536, 131071, 12000};
		sum_acc = 0;
		prev_mean = 0;
		flk_ofs = 0;
		hist_ok = 1'b0;
		frame_ready = 1'b0;
		bypass_on = 1'b0;
		load_pos = 0;
		emit_pos = 0;
		last_w = 0;
		last_h = 0;
		loaded_n = 0;
		stab_reg = 0;
		gain_reg = 0;
		width_reg = 256;
		height_reg = 256;
		base = 30000;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: emit with no frame, clear, no-op, then 1x1 frames that run
		// through saturation, bypass, strong edges and both flicker signs.
		push_req(tdbf_pkg::OP_EMIT, 0);
		push_req(tdbf_pkg::OP_NOP, 17'h1FFFF);
		push_req(tdbf_pkg::OP_CLEAR, 0);
		push_req(tdbf_pkg::OP_EMIT, 17'h1FFFF);
		set_filter(62259, 65536, 1, 1);
		push_req(tdbf_pkg::OP_LOAD, 17'h1FFFF);
		push_req(tdbf_pkg::OP_EMIT, 0);
		push_req(tdbf_pkg::OP_LOAD, 0);
		push_req(tdbf_pkg::OP_EMIT, 0);
		push_req(tdbf_pkg::OP_LOAD, 30000);
		push_req(tdbf_pkg::OP_EMIT, 0);
		push_req(tdbf_pkg::OP_LOAD, 40000);
		push_req(tdbf_pkg::OP_EMIT, 0);
		push_req(tdbf_pkg::OP_CLEAR, 0);
		push_req(tdbf_pkg::OP_LOAD, 1000);
		push_req(tdbf_pkg::OP_EMIT, 0);
		push_req(tdbf_pkg::OP_EMIT, 0);
		set_filter(65535, 131071, 0, 0);
		push_req(tdbf_pkg::OP_LOAD, 65536);
		push_req(tdbf_pkg::OP_EMIT, 0);
		push_req(tdbf_pkg::OP_LOAD, 20000);
		push_req(tdbf_pkg::OP_LOAD, 5);
		push_req(tdbf_pkg::OP_EMIT, 0);

		// Extreme frame sizes, one frame each.
		set_filter(40000, 30000, 256, 1);
		send_frame(base);
		set_filter(40000, 30000, 1, 256);
		send_frame(base);

		// Random phases with mostly small frames.
		while (items_sent < 1400) begin
			s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: stab_pick[$urandom_range(0, 8)];
			g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65536)
				: gain_pick[$urandom_range(0, 4)];
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 8);
			if ($urandom_range(0, 9) == 0)
				w = 0;
			if (items_sent > 1100)
				gaps_on = 1'b0;
			set_filter(s, g, w, h);
			frames = $urandom_range(2, 6);
			for (int f = 0; f < frames; f++)
				send_frame(base);
			if (!hold_go && items_sent > 600) begin
				for (int k = 0; k < 16; k++)
					push_req(tdbf_pkg::OP_LOAD, pick_depth(base));
				for (int k = 0; k < 16; k++)
					push_req(tdbf_pkg::OP_EMIT, 0);
				hold_go = 1'b1;
			end
		end

		drain_block();
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
